FILE: sv/ahfr_pkg.sv
// Package for the ASCII-hex frame receiver: word types, codes and the hex decode.
`default_nettype none
package ahfr_pkg;

    localparam int NODE_COUNT_DEF = 8;

    // operation codes
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_CHAR    = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // configuration register indexes
    localparam logic CFG_NODE_ADDRESS = 1'b0;
    localparam logic CFG_IS_MASTER    = 1'b1;

    // frame status codes
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_IDLE_TMO   = 4'd1;
    localparam logic [3:0] ST_WRONG_ADDR = 4'd2;
    localparam logic [3:0] ST_CANCEL     = 4'd3;
    localparam logic [3:0] ST_BAD_TYPE   = 4'd4;
    localparam logic [3:0] ST_FULL       = 4'd5;
    localparam logic [3:0] ST_CHECKSUM   = 4'd6;
    localparam logic [3:0] ST_SHORT      = 4'd7;
    localparam logic [3:0] ST_BAD_DEST   = 4'd8;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] HEX_TEN = 8'd10;
    localparam logic [7:0] CH_LF   = 8'h0A;

    typedef enum logic [1:0] {
        PH_ADDR,
        PH_RECV,
        PH_TAIL
    } phase_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] char_value;
        logic       address_mark;
        logic [2:0] polled_node;
    } in_word_t;

    typedef struct packed {
        logic       kind;
        logic [3:0] status;
        logic [7:0] data_byte;
        logic [7:0] hw_source;
        logic       message_type;
        logic [7:0] source_node;
        logic [7:0] dest_node;
        logic [7:0] payload_length;
        logic [7:0] master_address;
    } out_word_t;

    function automatic logic [7:0] hex_digit(input logic [7:0] c);
        if (c > CH_NINE)
        begin
            return c - CH_A + HEX_TEN;
        end
        return c - CH_ZERO;
    endfunction

endpackage
`default_nettype wire

FILE: sv/ascii_hex_frame_receiver.sv
// ASCII-hex frame receiver: one character word per cycle while out is not stalled, decode into result words.
// Path: a word is held in the input register in_word_reg; its result is registered into out_word_reg
//   and shows on out with out_valid.
// Throughput: one word per cycle while out is not stalled; the per-character decode, add and compare are combinational.
// Reset: rst_n asynchronous active low clears frame state, full flags and the
//   registers node_address and is_master; no clearing pass.
`default_nettype none
module ascii_hex_frame_receiver #(
    parameter int NODE_COUNT = ahfr_pkg::NODE_COUNT_DEF
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire ahfr_pkg::in_word_t  in_data,
    output logic                     out_valid,
    input  wire                      out_ready,
    output ahfr_pkg::out_word_t      out_data,
    input  wire                      cfg_valid,
    output logic                     cfg_ready,
    input  wire                      cfg_index,
    input  wire  [3:0]               cfg_data
);
    import ahfr_pkg::*;

    localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic [8:0] NC9 = 9'(NODE_COUNT);

    logic [3:0]            node_address_reg;
    logic                  is_master_reg;

    logic                  in_valid_reg;
    in_word_t              in_word_reg;
    logic                  out_valid_reg;
    out_word_t             out_word_reg;

    phase_t                phase_reg, phase_next;
    logic [9:0]            char_position_reg, char_position_next;
    logic [3:0]            high_nibble_reg, high_nibble_next;
    logic [7:0]            running_sum_reg, running_sum_next;
    logic [7:0]            field_values_reg [5];
    logic [7:0]            field_values_next [5];
    logic [3:0]            pending_error_reg, pending_error_next;
    logic [NODE_COUNT-1:0] full_flags_reg, full_flags_next;
    logic [2:0]            awaited_node_reg, awaited_node_next;
    logic [7:0]            learned_master_reg, learned_master_next;

    logic                  res_valid;
    out_word_t             res_word;
    logic                  advance;

    logic [7:0]            own;
    logic [7:0]            digit;
    logic [7:0]            pair_value;
    logic [8:0]            pair_index;
    logic [7:0]            awaited_ext;
    logic [IDX_W-1:0]      awaited_idx;
    logic [IDX_W-1:0]      pair_idx;
    logic [IDX_W-1:0]      dest_idx;
    logic                  finish;
    logic [3:0]            finish_status;

    assign cfg_ready = 1'b1;
    assign own        = 8'(node_address_reg) + CH_ZERO;
    assign digit      = hex_digit(in_word_reg.char_value);
    assign pair_value = {high_nibble_reg, 4'b0000} + digit;
    assign pair_index = char_position_reg[9:1];
    assign awaited_ext = {5'b00000, awaited_node_reg};
    assign awaited_idx = awaited_ext[IDX_W-1:0];
    assign pair_idx    = pair_value[IDX_W-1:0];
    assign dest_idx    = field_values_reg[3][IDX_W-1:0];

    assign advance  = in_valid_reg && (!res_valid || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    always_comb
    begin
        phase_next          = phase_reg;
        char_position_next  = char_position_reg;
        high_nibble_next    = high_nibble_reg;
        running_sum_next    = running_sum_reg;
        field_values_next   = field_values_reg;
        pending_error_next  = pending_error_reg;
        full_flags_next     = full_flags_reg;
        awaited_node_next   = awaited_node_reg;
        learned_master_next = learned_master_reg;
        finish        = 1'b0;
        finish_status = ST_OK;
        res_valid     = 1'b0;

        res_word.kind           = KIND_DATA;
        res_word.status         = ST_OK;
        res_word.data_byte      = 8'd0;
        res_word.hw_source      = field_values_reg[0];
        res_word.message_type   = field_values_reg[1][0];
        res_word.source_node    = field_values_reg[2];
        res_word.dest_node      = field_values_reg[3];
        res_word.payload_length = field_values_reg[4];
        res_word.master_address = learned_master_reg;

        case (in_word_reg.operation)
            OP_START:
            begin
                awaited_node_next  = in_word_reg.polled_node;
                phase_next         = PH_ADDR;
                char_position_next = '0;
                high_nibble_next   = '0;
                running_sum_next   = '0;
                pending_error_next = ST_OK;
                for (int i = 0; i < 5; i++)
                begin
                    field_values_next[i] = '0;
                end
            end
            OP_TIMEOUT:
            begin
                finish        = 1'b1;
                finish_status = (phase_reg == PH_ADDR) ? ST_IDLE_TMO : ST_CANCEL;
            end
            OP_CHAR:
            begin
                if (phase_reg == PH_ADDR)
                begin
                    if (in_word_reg.address_mark)
                    begin
                        if (is_master_reg && ({6'b000000, awaited_node_reg} < NC9))
                        begin
                            full_flags_next[awaited_idx] = 1'b0;
                        end
                        if (in_word_reg.char_value != own)
                        begin
                            // master reports a foreign reply; slave just skips it
                            if (is_master_reg)
                            begin
                                finish        = 1'b1;
                                finish_status = ST_WRONG_ADDR;
                            end
                        end
                        else
                        begin
                            char_position_next = '0;
                            high_nibble_next   = '0;
                            running_sum_next   = 8'(node_address_reg);
                            pending_error_next = ST_OK;
                            for (int i = 0; i < 5; i++)
                            begin
                                field_values_next[i] = '0;
                            end
                            phase_next = PH_RECV;
                        end
                    end
                end
                else if (in_word_reg.char_value == CH_LF)
                begin
                    finish = 1'b1;
                    if (phase_reg == PH_RECV)
                    begin
                        finish_status = ST_SHORT;
                    end
                    else
                    begin
                        finish_status = pending_error_reg;
                        if (pending_error_reg == ST_OK && is_master_reg &&
                            field_values_reg[1] == 8'd1 &&
                            {1'b0, field_values_reg[3]} < NC9)
                        begin
                            full_flags_next[dest_idx] = 1'b1;
                        end
                    end
                end
                else if (phase_reg == PH_RECV)
                begin
                    char_position_next = char_position_reg + 10'd1;
                    if (!char_position_reg[0])
                    begin
                        high_nibble_next = digit[3:0];
                    end
                    else if (pair_index == 9'd0)
                    begin
                        field_values_next[0] = pair_value;
                        running_sum_next     = running_sum_reg + pair_value;
                        if (!is_master_reg)
                        begin
                            learned_master_next = pair_value;
                        end
                    end
                    else if (pair_index == 9'd1)
                    begin
                        field_values_next[1] = pair_value;
                        if (pair_value > 8'd1)
                        begin
                            pending_error_next = ST_BAD_TYPE;
                            phase_next         = PH_TAIL;
                        end
                        else
                        begin
                            running_sum_next = running_sum_reg + pair_value;
                        end
                    end
                    else if (field_values_reg[1] == 8'd0 ||
                             pair_index == 9'd5 + {1'b0, field_values_reg[4]})
                    begin
                        // checksum pair
                        pending_error_next = (pair_value == running_sum_reg) ?
                                             ST_OK : ST_CHECKSUM;
                        phase_next = PH_TAIL;
                    end
                    else if (pair_index <= 9'd4)
                    begin
                        field_values_next[pair_index[2:0]] = pair_value;
                        running_sum_next = running_sum_reg + pair_value;
                        if (pair_index == 9'd3 && is_master_reg)
                        begin
                            if ({1'b0, pair_value} >= NC9)
                            begin
                                pending_error_next = ST_BAD_DEST;
                                phase_next         = PH_TAIL;
                            end
                            else if (full_flags_reg[pair_idx])
                            begin
                                pending_error_next = ST_FULL;
                                phase_next         = PH_TAIL;
                            end
                        end
                    end
                    else
                    begin
                        running_sum_next   = running_sum_reg + pair_value;
                        res_valid          = 1'b1;
                        res_word.data_byte = pair_value;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (finish)
        begin
            res_valid          = 1'b1;
            res_word.kind      = KIND_STATUS;
            res_word.status    = finish_status;
            phase_next         = PH_ADDR;
            char_position_next = '0;
            high_nibble_next   = '0;
            running_sum_next   = '0;
            pending_error_next = ST_OK;
            for (int i = 0; i < 5; i++)
            begin
                field_values_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg <= '0;
            is_master_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NODE_ADDRESS: node_address_reg <= cfg_data;
                CFG_IS_MASTER:    is_master_reg    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            phase_reg          <= PH_ADDR;
            char_position_reg  <= '0;
            high_nibble_reg    <= '0;
            running_sum_reg    <= '0;
            pending_error_reg  <= ST_OK;
            full_flags_reg     <= '0;
            awaited_node_reg   <= '0;
            learned_master_reg <= '0;
            for (int i = 0; i < 5; i++)
            begin
                field_values_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                phase_reg          <= phase_next;
                char_position_reg  <= char_position_next;
                high_nibble_reg    <= high_nibble_next;
                running_sum_reg    <= running_sum_next;
                field_values_reg   <= field_values_next;
                pending_error_reg  <= pending_error_next;
                full_flags_reg     <= full_flags_next;
                awaited_node_reg   <= awaited_node_next;
                learned_master_reg <= learned_master_next;
            end
            if (advance && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_word_reg <= in_data;
        end
        if (advance && res_valid)
        begin
            out_word_reg <= res_word;
        end
    end

    // between frames nothing partial may linger
    a_addr_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ADDR |-> char_position_reg == 10'd0 && pending_error_reg == ST_OK)
        else $error("frame state left over while awaiting address");

    a_error_in_tail: assert property (@(posedge clk) disable iff (!rst_n)
        pending_error_reg != ST_OK |-> phase_reg == PH_TAIL)
        else $error("pending error outside tail phase");

    a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.kind == KIND_DATA |-> out_word_reg.status == ST_OK)
        else $error("data word carries a status");

    a_held_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_word_reg))
        else $error("stalled input word lost");

endmodule
`default_nettype wire
